// ===== rtl/mrq_pkg.sv =====
package mrq_pkg;

  // Default sizing of the ready queue.
  localparam int MRQ_LEVELS      = 8;
  localparam int MRQ_LEVEL_DEPTH = 16;
  localparam int MRQ_ID_BITS     = 8;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_MULTILEVEL_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PREEMPT_ENABLE  = 2'd2;

  // Packed widths of the stream payloads.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

endpackage

// ===== rtl/multilevel_ready_queue_preempt.sv =====
// Channel  Direction  Handshake             Payload
// in       slave      in_tvalid/in_tready   in_tuser: req_type; in_tdata: task fields
// out      master     out_tvalid/out_tready out_tdata: found, id, level, preempt, overflow
// cfg      slave      cfg_valid/cfg_ready   cfg_index, cfg_data (register write)
//
// One request is taken in every cycle in which the result register is empty or
// is being emptied; its result appears in the cycle after it is taken.
// The popped task id is read from the slot memory's registered read port, so
// it is registered together with the rest of the result.
// Reset (rst_n low at a clock edge) empties every level, restores the
// configuration registers and clears out_tvalid; the slot memory is not cleared.
// While a result waits with out_tready low, in_tready is low and no request is taken.
module multilevel_ready_queue_preempt
  import mrq_pkg::*;
#(
  parameter int LEVELS      = MRQ_LEVELS,
  parameter int LEVEL_DEPTH = MRQ_LEVEL_DEPTH,
  parameter int ID_BITS     = MRQ_ID_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input requests.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] req_type
  input  logic                   in_tuser,
  // [7:0] task_id, [15:8] task_priority, [18:16] running_worst_priority,
  // [19] all_processors_busy, [23:20] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Results.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] found, [8:1] out_task_id, [11:9] out_level, [12] preempt_request,
  // [13] overflow, [15:14] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int N_W    = $clog2(LEVELS + 1);
  localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  logic                  mode_r;
  logic [CFG_DATA_W-1:0] lvl_cnt_r;
  logic                  pe_r;

  // Per-level FIFO bookkeeping, held in flip-flops.
  logic [PTR_W-1:0] heads_r  [LEVELS];
  logic [PTR_W-1:0] heads_nxt[LEVELS];
  logic [PTR_W-1:0] tails_r  [LEVELS];
  logic [PTR_W-1:0] tails_nxt[LEVELS];
  logic [CNT_W-1:0] counts_r  [LEVELS];
  logic [CNT_W-1:0] counts_nxt[LEVELS];

  // Shared slot memory, one region of LEVEL_DEPTH entries per level.
  logic [ID_BITS-1:0] slots[SLOTS];
  logic [ID_BITS-1:0] rd_data_r;

  // Result register.
  logic           out_valid_r, out_valid_nxt;
  logic           found_r, found_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic           preempt_r, preempt_nxt;
  logic           ovf_r, ovf_nxt;

  // Decoded request.
  logic              accept;
  logic              req_deq;
  logic [7:0]        id_in;
  logic signed [7:0] prio;
  logic [2:0]        worst;
  logic              busy;

  logic [N_W-1:0]    n_act;
  logic [LEVELS-1:0] nonempty;
  logic [LEVELS-1:0] post_nonempty;
  logic [LVL_W-1:0]  enq_lvl;
  logic              full;
  logic              deq_hit;
  logic [LVL_W-1:0]  deq_lvl;
  logic              urgent_waiting;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign req_deq = (in_tuser == REQ_DEQUEUE);
  assign id_in   = in_tdata[7:0];
  assign prio    = signed'(in_tdata[15:8]);
  assign worst   = in_tdata[18:16];
  assign busy    = in_tdata[19];

  // Number of levels in use: one in single mode, else the register clamped
  // to the range one up to LEVELS.
  always_comb begin
    if (!mode_r) begin
      n_act = N_W'(1);
    end else if (lvl_cnt_r == '0) begin
      n_act = N_W'(1);
    end else if (lvl_cnt_r > LEVELS) begin
      n_act = N_W'(LEVELS);
    end else begin
      n_act = N_W'(lvl_cnt_r);
    end
  end

  // Target level of an enqueue: the priority clamped into the levels in use.
  always_comb begin
    if (!mode_r || prio < 0) begin
      enq_lvl = '0;
    end else if (prio[6:0] >= n_act) begin
      enq_lvl = LVL_W'(n_act - 1'b1);
    end else begin
      enq_lvl = LVL_W'(prio[6:0]);
    end
  end

  assign full = (counts_r[enq_lvl] == CNT_W'(LEVEL_DEPTH));

  // Lowest-numbered non-empty level in use. Scanning downwards leaves the
  // lowest match in place.
  always_comb begin
    deq_hit = 1'b0;
    deq_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (counts_r[i] != '0);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (i < n_act && nonempty[i]) begin
        deq_hit = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  // The preemption check looks at the queues as they stand after the enqueue.
  always_comb begin
    post_nonempty = nonempty;
    if (!full) begin
      post_nonempty[enq_lvl] = 1'b1;
    end
    urgent_waiting = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (i < worst && i < n_act && post_nonempty[i]) begin
        urgent_waiting = 1'b1;
      end
    end
  end

  // Next state of the level bookkeeping and the memory write.
  always_comb begin
    heads_nxt  = heads_r;
    tails_nxt  = tails_r;
    counts_nxt = counts_r;
    wr_en      = 1'b0;
    if (accept && !req_deq && !full) begin
      wr_en               = 1'b1;
      tails_nxt[enq_lvl]  = ptr_inc(tails_r[enq_lvl]);
      counts_nxt[enq_lvl] = counts_r[enq_lvl] + 1'b1;
    end
    if (accept && req_deq && deq_hit) begin
      heads_nxt[deq_lvl]  = ptr_inc(heads_r[deq_lvl]);
      counts_nxt[deq_lvl] = counts_r[deq_lvl] - 1'b1;
    end
  end

  assign wr_addr = ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tails_r[enq_lvl]);
  assign rd_addr = ADDR_W'(deq_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(heads_r[deq_lvl]);

  // Result of the request being taken.
  always_comb begin
    found_nxt   = req_deq && deq_hit;
    ovf_nxt     = !req_deq && full;
    preempt_nxt = !req_deq && mode_r && pe_r && busy && urgent_waiting;
    if (req_deq) begin
      level_nxt = deq_hit ? deq_lvl : '0;
    end else begin
      level_nxt = enq_lvl;
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Slot memory: one write and one registered read per cycle. The read is
  // only enabled on an accepted request so the popped id holds during a stall.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= ID_BITS'(id_in);
    end
    if (accept) begin
      rd_data_r <= slots[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      lvl_cnt_r <= CFG_DATA_W'(1);
      pe_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MULTILEVEL_MODE: mode_r    <= cfg_data[0];
        REG_LEVEL_COUNT:     lvl_cnt_r <= cfg_data;
        REG_PREEMPT_ENABLE:  pe_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        tails_r[i]  <= '0;
        counts_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      heads_r     <= heads_nxt;
      tails_r     <= tails_nxt;
      counts_r    <= counts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r   <= found_nxt;
      level_r   <= level_nxt;
      preempt_r <= preempt_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, ovf_r, preempt_r, 3'(level_r),
                       (found_r ? 8'(rd_data_r) : 8'd0), found_r};

  // A dequeue that finds an active non-empty level returns it next cycle.
  a_deq_found: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_deq && deq_hit) |=> (out_tvalid && out_tdata[0]))
    else $error("dequeue of a non-empty queue did not report a task");

  // An enqueue into a full level leaves its count unchanged and is flagged.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !req_deq && full) |=> (out_tdata[13] && counts_r[$past(enq_lvl)] ==
                                      CNT_W'(LEVEL_DEPTH)))
    else $error("overflow not flagged or full level changed");

  // A found task never comes with an enqueue-only flag.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (!out_tdata[12] && !out_tdata[13]))
    else $error("found raised together with preempt or overflow");

  // Level zero never holds more entries than its depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counts_r[0] <= CNT_W'(LEVEL_DEPTH))
    else $error("level count beyond depth");

  // A result waiting on a stalled output holds steady, since no new request is taken.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result register changed under a stall");

endmodule

// ===== tb/sv/tb_multilevel_ready_queue_preempt.sv =====
`timescale 1ns / 1ps

module tb_multilevel_ready_queue_preempt;
  import mrq_pkg::*;

  localparam int NLEV  = MRQ_LEVELS;
  localparam int DEPTH = MRQ_LEVEL_DEPTH;

  // Index 3 is not a register; the block must leave every setting alone on it.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  // Generous ceiling on the run.
  localparam int TIMEOUT_NS = 4_000_000;

  localparam int RANDOM_ITEMS = 850;

  // One scheduler request as it travels on the input channel.
  typedef struct packed {
    logic       kind;
    logic       busy;
    logic [2:0] worst;
    logic [7:0] prio;
    logic [7:0] task_id;
  } sched_req_t;

  // Result word, laid out exactly as out_tdata from the highest bit down.
  typedef struct packed {
    logic [1:0] pad;
    logic       overflow;
    logic       preempt;
    logic [2:0] level;
    logic [7:0] task_id;
    logic       found;
  } sched_result_t;

  // Every input starts at a known value; the block is held in reset from time zero.
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic                   in_tuser   = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  multilevel_ready_queue_preempt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the ready queue. It is advanced once for every request the
  // block accepts and once for every register write, so it always mirrors the
  // state that the block should hold.
  // ---------------------------------------------------------------------------
  logic [MRQ_ID_BITS-1:0] slot_mem [NLEV][DEPTH];
  int                     head_ptr [NLEV];
  int                     tail_ptr [NLEV];
  int                     fill     [NLEV];
  logic                   ml_mode;
  logic [3:0]             lvl_count;
  logic                   preempt_en;

  sched_req_t    req_queue[$];    // requests still to be offered to the block
  sched_result_t reply_queue[$];  // results owed by the block, oldest first
  sched_req_t    cur_req;         // request currently on the input channel
  sched_result_t got_reply;
  sched_result_t want_reply;

  int cyc        = 0;
  int n_queued   = 0;
  int n_taken    = 0;
  int n_results  = 0;
  int n_found    = 0;
  int n_preempt  = 0;
  int n_overflow = 0;
  int n_cfg      = 0;
  int errors     = 0;

  task automatic reset_model();
    for (int l = 0; l < NLEV; l++) begin
      head_ptr[l] = 0;
      tail_ptr[l] = 0;
      fill[l]     = 0;
    end
    ml_mode    = 1'b0;
    lvl_count  = 4'd1;
    preempt_en = 1'b0;
  endtask

  // Number of levels that take part in popping and in the preemption check.
  // A count of zero behaves as one, and anything beyond the build size is
  // capped there.
  function automatic int levels_in_use();
    if (!ml_mode) return 1;
    if (lvl_count == 0) return 1;
    if (int'(lvl_count) > NLEV) return NLEV;
    return int'(lvl_count);
  endfunction

  // Applies one request to the shadow queue and returns the result it owes.
  function automatic sched_result_t schedule_step(sched_req_t r);
    sched_result_t res;
    int            n;
    int            lvl;
    int            pr;
    n   = levels_in_use();
    res = '0;
    if (r.kind == REQ_ENQUEUE) begin
      pr  = signed'(r.prio);
      lvl = 0;
      // Clamp the requested priority onto the levels that are in use.
      if (ml_mode) begin
        if (pr < 0) lvl = 0;
        else if (pr >= n) lvl = n - 1;
        else lvl = pr;
      end
      res.level = lvl[2:0];
      if (fill[lvl] >= DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        slot_mem[lvl][tail_ptr[lvl]] = r.task_id;
        tail_ptr[lvl] = (tail_ptr[lvl] + 1) % DEPTH;
        fill[lvl]++;
      end
      // The check sees the queues after the enqueue, or unchanged if it was dropped.
      if (ml_mode && preempt_en && r.busy) begin
        for (int l = 0; l < int'(r.worst) && l < n; l++) begin
          if (fill[l] != 0) res.preempt = 1'b1;
        end
      end
    end else begin
      for (int l = 0; l < n; l++) begin
        if (fill[l] != 0 && !res.found) begin
          res.found   = 1'b1;
          res.level   = l[2:0];
          res.task_id = slot_mem[l][head_ptr[l]];
          head_ptr[l] = (head_ptr[l] + 1) % DEPTH;
          fill[l]--;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Back-pressure and gaps. Outside the quiet window each side holds off at
  // random, eleven times in a hundred; inside it both sides run flat out.
  // ---------------------------------------------------------------------------
  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit take_gap();
    if ((cyc % 2000) >= 1500) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  // Input driver: offers queued requests, keeps each one steady until the block
  // takes it, and records the owed result at the edge of acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        reply_queue.push_back(schedule_step(cur_req));
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() != 0 && !take_gap()) begin
          cur_req = req_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_req.kind;
          in_tdata  <= {4'b0000, cur_req.busy, cur_req.worst, cur_req.prio,
                        cur_req.task_id};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_reply = sched_result_t'(out_tdata);
      n_results++;
      if (reply_queue.size() == 0) begin
        errors++;
        $display("%0t ns: result %h arrived with no request outstanding",
                 $time, out_tdata);
      end else begin
        want_reply = reply_queue.pop_front();
        if (got_reply !== want_reply) begin
          errors++;
          $display("%0t ns: mismatch expected found=%0b id=%0d level=%0d preempt=%0b ovf=%0b pad=%0d",
                   $time, want_reply.found, want_reply.task_id, want_reply.level,
                   want_reply.preempt, want_reply.overflow, want_reply.pad);
          $display("%0t ns:          actual   found=%0b id=%0d level=%0d preempt=%0b ovf=%0b pad=%0d",
                   $time, got_reply.found, got_reply.task_id, got_reply.level,
                   got_reply.preempt, got_reply.overflow, got_reply.pad);
        end
        n_found    += want_reply.found;
        n_preempt  += want_reply.preempt;
        n_overflow += want_reply.overflow;
      end
    end
    out_tready <= !take_gap();
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic kind, input logic [7:0] id, input logic [7:0] prio,
                           input logic [2:0] worst, input logic busy);
    sched_req_t r;
    r.kind    = kind;
    r.task_id = id;
    r.prio    = prio;
    r.worst   = worst;
    r.busy    = busy;
    req_queue.push_back(r);
    n_queued++;
  endtask

  // Mostly priorities around the levels in use, sometimes anything at all.
  function automatic logic [7:0] rand_prio();
    int p;
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    p = $urandom_range(0, 10) - 1;
    return 8'(p);
  endfunction

  function automatic logic rand_busy();
    return $urandom_range(0, 9) < 7;
  endfunction

  // Waits until every request has been taken and its result has come back,
  // then lets a little margin go by.
  task automatic wait_idle();
    do @(posedge clk); while (n_taken != n_queued || reply_queue.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MULTILEVEL_MODE: ml_mode    = val[0];
      REG_LEVEL_COUNT:     lvl_count  = val;
      REG_PREEMPT_ENABLE:  preempt_en = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // Registers change only once the block has drained.
  task automatic set_config(input logic ml, input logic [3:0] lc, input logic pe);
    wait_idle();
    write_reg(REG_MULTILEVEL_MODE, {3'b000, ml});
    write_reg(REG_LEVEL_COUNT, lc);
    write_reg(REG_PREEMPT_ENABLE, {3'b000, pe});
  endtask

  // Settings visited first by the random phases: the extremes of the level
  // count, both modes and preemption on and off. Packed as {mode, count, enable}.
  logic [5:0] cfg_plan [10] = '{
    {1'b1, 4'd8,  1'b1}, {1'b1, 4'd1, 1'b1}, {1'b1, 4'd0, 1'b1}, {1'b1, 4'd15, 1'b1},
    {1'b0, 4'd8,  1'b1}, {1'b1, 4'd3, 1'b0}, {1'b1, 4'd9, 1'b1}, {1'b0, 4'd0,  1'b0},
    {1'b1, 4'd7,  1'b1}, {1'b1, 4'd2, 1'b1}
  };

  initial begin : stimulus
    int         phase;
    int         made;
    int         target;
    int         burst;
    int         pops;
    logic [7:0] burst_prio;
    logic [5:0] plan;

    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Single-queue mode straight out of reset: an empty pop, then an entry with
    // extreme fields that must land on level 0 without any preemption flag, and its pop.
    queue_req(REQ_DEQUEUE, 8'h00, 8'h00, 3'd0, 1'b0);
    queue_req(REQ_ENQUEUE, 8'hFF, 8'h80, 3'd7, 1'b1);
    queue_req(REQ_DEQUEUE, 8'hFF, 8'h7F, 3'd7, 1'b1);

    // Eight levels with preemption: clamping at both ends, the busy and worst
    // priority gates, pops in level order and an empty pop at the end.
    set_config(1'b1, 4'd8, 1'b1);
    queue_req(REQ_ENQUEUE, 8'h81, 8'h80, 3'd7, 1'b1);
    queue_req(REQ_ENQUEUE, 8'h5A, 8'h7F, 3'd0, 1'b1);
    queue_req(REQ_ENQUEUE, 8'hA5, 8'h03, 3'd7, 1'b0);
    queue_req(REQ_ENQUEUE, 8'h3C, 8'h05, 3'd3, 1'b1);
    repeat (5) queue_req(REQ_DEQUEUE, 8'h00, 8'h00, 3'd0, 1'b0);

    // Fill level 2 beyond its depth so that the last enqueue is dropped.
    for (int k = 0; k < DEPTH + 1; k++) queue_req(REQ_ENQUEUE, 8'(k), 8'h02, 3'd4, 1'b1);

    // Shrink to two levels: the full level 2 is stranded and must stay untouched.
    set_config(1'b1, 4'd2, 1'b0);
    queue_req(REQ_ENQUEUE, 8'hC3, 8'h06, 3'd7, 1'b1);
    queue_req(REQ_DEQUEUE, 8'h00, 8'h00, 3'd0, 1'b0);
    queue_req(REQ_DEQUEUE, 8'h00, 8'h00, 3'd0, 1'b0);

    // The spare index must be ignored.
    wait_idle();
    write_reg(REG_SPARE, 4'hF);

    // Random phases. Most traffic is bursts of enqueues followed by pops, so
    // that levels fill, overflow, drain and get stranded across reconfiguration;
    // the rest is single requests of either kind.
    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      plan = (phase < 10) ? cfg_plan[phase] : 6'($urandom);
      set_config(plan[5], plan[4:1], plan[0]);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 4'($urandom));
      target = made + $urandom_range(40, 80);
      while (made < target) begin
        if ($urandom_range(0, 9) < 7) begin
          burst      = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 20)
                                                   : $urandom_range(1, 6);
          burst_prio = rand_prio();
          for (int k = 0; k < burst; k++) begin
            queue_req(REQ_ENQUEUE, 8'($urandom),
                      (burst > 10) ? burst_prio : rand_prio(),
                      3'($urandom_range(0, 7)), rand_busy());
          end
          pops = $urandom_range(0, burst + 2);
          for (int k = 0; k < pops; k++) begin
            queue_req(REQ_DEQUEUE, 8'($urandom), rand_prio(),
                      3'($urandom_range(0, 7)), rand_busy());
          end
          made += burst + pops;
        end else begin
          queue_req(1'($urandom), 8'($urandom), rand_prio(),
                    3'($urandom_range(0, 7)), rand_busy());
          made++;
        end
      end
      phase++;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (reply_queue.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, reply_queue.size());
    end

    $display("Covered %0d requests in %0d phases with %0d register writes.",
             n_taken, phase, n_cfg);
    $display("Results seen: %0d, of which %0d pops found a task, %0d preempted, %0d dropped.",
             n_results, n_found, n_preempt, n_overflow);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timed out with %0d requests taken of %0d and %0d results outstanding.",
             n_taken, n_queued, reply_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mrq_pkg.sv
rtl/multilevel_ready_queue_preempt.sv
tb/sv/tb_multilevel_ready_queue_preempt.sv
